FILE: rtl/friction_circle_velocity_integrator_macros.svh
// assertion macros for the velocity integrator
// used by the top level, no other dependencies
`ifndef FRICTION_CIRCLE_VELOCITY_INTEGRATOR_MACROS_SVH
`define FRICTION_CIRCLE_VELOCITY_INTEGRATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define FCVI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FCVI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FCVI_ASSERT(lbl, clk, rst_n, prop, msg)
`define FCVI_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: rtl/fcvi_pkg.sv
// shared constants and types for the velocity integrator
// no dependencies
package fcvi_pkg;

    // fixed-point format of velocity, accelerations and distance
    localparam int FRAC_BITS = 16;
    // shift after a product with a Q0.24 factor and a Q(2F) square
    localparam int SH_SQ = 24 + FRAC_BITS;

    // register indexes on the configuration port
    localparam logic [2:0] CFG_NORMAL_LIMIT = 3'd0;
    localparam logic [2:0] CFG_ACCEL_LIMIT  = 3'd1;
    localparam logic [2:0] CFG_BRAKE_LIMIT  = 3'd2;
    localparam logic [2:0] CFG_DRAG         = 3'd3;
    localparam logic [2:0] CFG_SPEED_CEIL   = 3'd4;
    localparam logic [2:0] CFG_TIME_STEP    = 3'd5;

    // register reset values
    localparam logic [22:0] RST_NORMAL_LIMIT = 23'd524288;
    localparam logic [22:0] RST_ACCEL_LIMIT  = 23'd327680;
    localparam logic [23:0] RST_BRAKE_LIMIT  = 24'hFB0000;
    localparam logic [23:0] RST_DRAG         = 24'd16777;
    localparam logic [30:0] RST_SPEED_CEIL   = 31'd3276800;
    localparam logic [23:0] RST_TIME_STEP    = 24'd167772;

    // intermediate magnitude ceiling
    localparam logic [47:0] MAG_CAP = 48'hFFFF_FFFF_FFFF;

    // digit-serial multiplier geometry
    localparam int MUL_AW    = 64;
    localparam int MUL_BW    = 32;
    localparam int MUL_DW    = 4;
    localparam int MUL_PW    = MUL_AW + MUL_BW;
    localparam int MUL_STEPS = MUL_BW / MUL_DW;
    localparam int MUL_CW    = $clog2(MUL_STEPS);

    typedef struct packed {
        logic              start;
        logic [MUL_AW-1:0] a;
        logic [MUL_BW-1:0] b;
    } t_mul_req;

endpackage

FILE: rtl/friction_circle_velocity_integrator.sv
// top level of the point-mass velocity integrator
// depends on fcvi_pkg, fcvi_mul and the assertion macro header
`include "friction_circle_velocity_integrator_macros.svh"

// One word in gives one result word out. Each word is worked on alone:
// the time goes to the shared digit-serial multiplier (nine products on
// a full step, four on one that hits the lateral limit) and, on a full
// step only, to the bit-serial square root and divider. The next word is
// taken once the previous result sits in the output register.
module friction_circle_velocity_integrator import fcvi_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_op,
    input  logic signed [15:0] i_control_u,
    input  logic signed [31:0] i_path_curvature,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [47:0] o_distance_out,
    output logic signed [31:0] o_velocity_out,
    output logic               o_lateral_limited,
    output logic               o_speed_clamped,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [30:0]        i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_VSQ, S_DRAG, S_ANM, S_DD, S_AN2, S_AX2,
        S_SQRT, S_DIV, S_ROOT, S_RDT, S_DVM, S_FIN
    } t_state;

    t_state r_state;

    // configuration
    logic [22:0] r_nal, r_acc;
    logic [23:0] r_brk, r_drag_c, r_ts;
    logic [30:0] r_ceil;
    // state
    logic [47:0] r_dist;
    logic [31:0] r_vel;
    // per-word work registers
    logic        r_back, r_lat, r_wait;
    logic [15:0] r_u;
    logic [31:0] r_cmag, r_vmag, r_ddm, r_rem;
    logic [62:0] r_vsq;
    logic [61:0] r_sx;
    logic [46:0] r_atm;
    logic [22:0] r_anm, r_drem;
    logic [45:0] r_an2;
    logic [30:0] r_q, r_dq, r_f;
    logic [47:0] r_root, r_rdt, r_dvm;
    logic [4:0]  r_cnt;
    // output register
    logic        r_out_valid, r_o_lat, r_o_clamp;
    logic [47:0] r_o_dist;
    logic [31:0] r_o_vel;

    t_mul_req          w_req;
    logic              w_done;
    logic [MUL_PW-1:0] w_prod;
    logic              w_is_mul, w_accept, w_fin_go;
    logic [15:0]       w_umag;
    logic              w_upos;
    logic [47:0]       w_lim, w_at, w_atm;
    logic [34:0]       w_strial;
    logic              w_sok;
    logic [31:0]       w_srem;
    logic [30:0]       w_sq;
    logic [24:0]       w_dtrial;
    logic              w_dok;
    logic [47:0]       w_ndist;
    logic signed [49:0] w_nv;
    logic              w_above, w_below;
    logic [31:0]       w_vel_new;

    fcvi_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_done),
        .o_prod  (w_prod)
    );

    // handshake
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_fin_go   = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

    assign w_umag = r_u[15] ? (16'd0 - r_u) : r_u;
    assign w_upos = !r_u[15] && (r_u != 16'd0);

    // multiplier operand select
    always_comb begin
        w_is_mul = 1'b1;
        w_req.a  = '0;
        w_req.b  = '0;
        unique case (r_state)
            S_VSQ:  begin w_req.a = {32'd0, r_vmag};  w_req.b = r_vmag; end
            S_DRAG: begin w_req.a = {1'd0, r_vsq};    w_req.b = {8'd0, r_drag_c}; end
            S_ANM:  begin w_req.a = {1'd0, r_vsq};    w_req.b = r_cmag; end
            S_DD:   begin w_req.a = {32'd0, r_vmag};  w_req.b = {8'd0, r_ts}; end
            S_AN2:  begin w_req.a = {41'd0, r_anm};   w_req.b = {9'd0, r_anm}; end
            S_AX2:  begin w_req.a = {41'd0, r_nal};   w_req.b = {9'd0, r_nal}; end
            S_ROOT: begin w_req.a = {17'd0, r_atm};   w_req.b = {1'b0, r_f}; end
            S_RDT:  begin w_req.a = {16'd0, r_root};  w_req.b = {8'd0, r_ts}; end
            S_DVM:  begin w_req.a = {16'd0, r_rdt};   w_req.b = {16'd0, w_umag}; end
            default: w_is_mul = 1'b0;
        endcase
        w_req.start = w_is_mul && !r_wait;
    end

    // tangential limit less drag, taken as a magnitude
    assign w_lim = w_upos ? {25'd0, r_acc} : {{24{r_brk[23]}}, r_brk};
    assign w_at  = w_lim - {2'd0, w_prod[SH_SQ+45:SH_SQ]};
    assign w_atm = w_at[47] ? (48'd0 - w_at) : w_at;

    // one square root bit per cycle
    assign w_strial = {1'b0, r_rem, r_sx[61:60]} - {2'd0, r_q, 2'b01};
    assign w_sok    = !w_strial[34];
    assign w_srem   = w_sok ? w_strial[31:0] : {r_rem[29:0], r_sx[61:60]};
    assign w_sq     = {r_q[29:0], w_sok};

    // one quotient bit per cycle
    assign w_dtrial = {1'b0, r_drem, r_dq[30]} - {2'd0, r_nal};
    assign w_dok    = !w_dtrial[24];

    // final update of distance and velocity
    assign w_ndist = (r_vel[31] ^ r_back) ? (r_dist - {16'd0, r_ddm})
                                          : (r_dist + {16'd0, r_ddm});
    assign w_nv = (r_u[15] ^ r_back)
                ? ($signed({{18{r_vel[31]}}, r_vel}) - $signed({2'd0, r_dvm}))
                : ($signed({{18{r_vel[31]}}, r_vel}) + $signed({2'd0, r_dvm}));
    assign w_above = w_nv > $signed({19'd0, r_ceil});
    assign w_below = w_nv[49] && !(&w_nv[48:31]);

    always_comb begin
        priority if (w_above) begin
            w_vel_new = {1'b0, r_ceil};
        end else if (w_below) begin
            w_vel_new = 32'h8000_0000;
        end else begin
            w_vel_new = w_nv[31:0];
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nal    <= RST_NORMAL_LIMIT;
            r_acc    <= RST_ACCEL_LIMIT;
            r_brk    <= RST_BRAKE_LIMIT;
            r_drag_c <= RST_DRAG;
            r_ceil   <= RST_SPEED_CEIL;
            r_ts     <= RST_TIME_STEP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NORMAL_LIMIT: r_nal    <= i_cfg_data[22:0];
                CFG_ACCEL_LIMIT:  r_acc    <= i_cfg_data[22:0];
                CFG_BRAKE_LIMIT:  r_brk    <= i_cfg_data[23:0];
                CFG_DRAG:         r_drag_c <= i_cfg_data[23:0];
                CFG_SPEED_CEIL:   r_ceil   <= i_cfg_data;
                CFG_TIME_STEP:    r_ts     <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // step sequencer, state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= 1'b0;
            r_out_valid <= 1'b0;
            r_dist      <= '0;
            r_vel       <= '0;
            r_cnt       <= '0;
        end else begin
            if (r_out_valid && i_out_ready && !w_fin_go) begin
                r_out_valid <= 1'b0;
            end
            if (w_req.start) begin
                r_wait <= 1'b1;
            end else if (w_done) begin
                r_wait <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_back  <= i_op;
                        r_u     <= i_control_u;
                        r_cmag  <= i_path_curvature[31] ? (32'd0 - i_path_curvature)
                                                        : i_path_curvature;
                        r_vmag  <= r_vel[31] ? (32'd0 - r_vel) : r_vel;
                        r_state <= S_VSQ;
                    end
                end
                S_VSQ: begin
                    if (w_done) begin
                        r_vsq   <= w_prod[62:0];
                        r_state <= S_DRAG;
                    end
                end
                S_DRAG: begin
                    if (w_done) begin
                        r_atm   <= w_atm[46:0];
                        r_state <= S_ANM;
                    end
                end
                S_ANM: begin
                    if (w_done) begin
                        r_lat   <= w_prod[MUL_PW-1:SH_SQ] >= {33'd0, r_nal};
                        r_anm   <= w_prod[SH_SQ+22:SH_SQ];
                        r_state <= S_DD;
                    end
                end
                S_DD: begin
                    if (w_done) begin
                        r_ddm <= w_prod[55:24];
                        if (r_lat) begin
                            r_dvm   <= '0;
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_AN2;
                        end
                    end
                end
                S_AN2: begin
                    if (w_done) begin
                        r_an2   <= w_prod[45:0];
                        r_state <= S_AX2;
                    end
                end
                S_AX2: begin
                    if (w_done) begin
                        r_sx    <= {w_prod[45:0] - r_an2, 16'd0};
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_cnt   <= '0;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_sx  <= {r_sx[59:0], 2'b00};
                    r_rem <= w_srem;
                    r_q   <= w_sq;
                    if (r_cnt == 5'd30) begin
                        // dividend is the root shifted up by 22
                        r_drem  <= w_sq[30:9];
                        r_dq    <= {w_sq[8:0], 22'd0};
                        r_f     <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DIV: begin
                    r_drem <= w_dok ? w_dtrial[22:0] : {r_drem[21:0], r_dq[30]};
                    r_dq   <= {r_dq[29:0], 1'b0};
                    r_f    <= {r_f[29:0], w_dok};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == 5'd30) begin
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (w_done) begin
                        r_root  <= (|w_prod[95:78]) ? MAG_CAP : w_prod[77:30];
                        r_state <= S_RDT;
                    end
                end
                S_RDT: begin
                    if (w_done) begin
                        r_rdt   <= (|w_prod[95:72]) ? MAG_CAP : w_prod[71:24];
                        r_state <= S_DVM;
                    end
                end
                S_DVM: begin
                    if (w_done) begin
                        r_dvm   <= (|w_prod[95:63]) ? MAG_CAP : w_prod[62:15];
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_fin_go) begin
                        r_dist      <= w_ndist;
                        r_vel       <= w_vel_new;
                        r_o_dist    <= w_ndist;
                        r_o_vel     <= w_vel_new;
                        r_o_lat     <= r_lat;
                        r_o_clamp   <= w_above;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_distance_out    = r_o_dist;
    assign o_velocity_out    = r_o_vel;
    assign o_lateral_limited = r_o_lat;
    assign o_speed_clamped   = r_o_clamp;

    // checks on the sequencer
    `FCVI_ASSERT(a_accept_leaves_idle, i_clk, i_rst_n, w_accept |=> (r_state == S_VSQ), "accepted word did not start a step")
    `FCVI_ASSERT(a_done_in_mul_state, i_clk, i_rst_n, w_done |-> (w_is_mul && r_wait), "product finished outside a multiply state")
    `FCVI_ASSERT(a_fin_sets_valid, i_clk, i_rst_n, w_fin_go |=> (r_out_valid && r_state == S_IDLE), "finished step did not post a result")

endmodule

FILE: rtl/fcvi_mul.sv
// digit-serial unsigned multiplier, four multiplier bits per cycle
// depends on fcvi_pkg
module fcvi_mul import fcvi_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mul_req          i_req,
    output logic              o_done,
    output logic [MUL_PW-1:0] o_prod
);

    logic [MUL_PW-1:0]        r_p;
    logic [MUL_AW-1:0]        r_a;
    logic                     r_busy;
    logic                     r_done;
    logic [MUL_CW-1:0]        r_cnt;
    logic [MUL_AW+MUL_DW-1:0] w_pp;
    logic [MUL_AW+MUL_DW-1:0] w_sum;
    logic [MUL_PW-1:0]        n_p;

    // partial product of one digit added to the upper half, then shift
    assign w_pp  = {{MUL_DW{1'b0}}, r_a} * {{MUL_AW{1'b0}}, r_p[MUL_DW-1:0]};
    assign w_sum = {{MUL_DW{1'b0}}, r_p[MUL_PW-1:MUL_BW]} + w_pp;
    assign n_p   = {w_sum, r_p[MUL_BW-1:MUL_DW]};

    // digit sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_p    <= {{MUL_AW{1'b0}}, i_req.b};
                r_a    <= i_req.a;
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_p   <= n_p;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MUL_CW'(MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;

endmodule
